// File: hdl/ptrk_pkg.sv
// ----------------------------------------------------------------------------
// ptrk_pkg: shared types and constants of the pointer tracker
// Command and register codes, word layouts of both channels, config bundle.
// ----------------------------------------------------------------------------
package ptrk_pkg;

  // Buttons tracked, and button fields carried by a sample word
  localparam int BUTTON_COUNT = 3;
  localparam int MAX_BUTTONS  = 3;

  localparam int POS_W    = 16;
  localparam int SUM_W    = 32;
  localparam int PRESS_W  = 8;
  localparam int BTN_IDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Fill count of a full result buffer
  localparam logic [1:0] OUT_BUF_FULL = 2'd2;

  // Window limits after reset
  localparam logic signed [POS_W-1:0] MIN_X_RESET = 16'sd0;
  localparam logic signed [POS_W-1:0] MIN_Y_RESET = 16'sd0;
  localparam logic signed [POS_W-1:0] MAX_X_RESET = 16'sd319;
  localparam logic signed [POS_W-1:0] MAX_Y_RESET = 16'sd199;

  typedef enum logic [2:0] {
    CMD_SAMPLE       = 3'd0,
    CMD_SET_POS      = 3'd1,
    CMD_FLUSH        = 3'd2,
    CMD_BUTTONS      = 3'd3,
    CMD_READ_DELTA   = 3'd4,
    CMD_DOWN_TIME    = 3'd5,
    CMD_DOWN_COUNT   = 3'd6,
    CMD_BUTTON_STATE = 3'd7
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 3'd0,
    CFG_MIN_X   = 3'd1,
    CFG_MIN_Y   = 3'd2,
    CFG_MAX_X   = 3'd3,
    CFG_MAX_Y   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [POS_W-1:0]  move_x;
    logic signed [POS_W-1:0]  move_y;
    logic [MAX_BUTTONS-1:0]   button_mask;
    logic [PRESS_W-1:0]       presses_0;
    logic [PRESS_W-1:0]       presses_1;
    logic [PRESS_W-1:0]       presses_2;
    logic [BTN_IDX_W-1:0]     button_index;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;
    logic [SUM_W-1:0]         now;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [SUM_W-1:0]  delta_x;
    logic signed [SUM_W-1:0]  delta_y;
    logic [SUM_W-1:0]         read_value;
  } out_word_t;

  typedef struct packed {
    logic                     enabled;
    logic signed [POS_W-1:0]  min_x;
    logic signed [POS_W-1:0]  min_y;
    logic signed [POS_W-1:0]  max_x;
    logic signed [POS_W-1:0]  max_y;
  } cfg_t;

endpackage

// File: hdl/ptrk_in_if.sv
// ----------------------------------------------------------------------------
// ptrk_in_if: command channel of the pointer tracker
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface ptrk_in_if;
  import ptrk_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ptrk_out_if.sv
// ----------------------------------------------------------------------------
// ptrk_out_if: result channel of the pointer tracker
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ptrk_out_if;
  import ptrk_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ptrk_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptrk_cfg_regs: configuration register file
// Enable flag and clamp window, written through a plain write port.
// ----------------------------------------------------------------------------
module ptrk_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ptrk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptrk_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  output ptrk_pkg::cfg_t                   cfg
);
  import ptrk_pkg::*;

  // Load the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= 1'b0;
      cfg.min_x   <= MIN_X_RESET;
      cfg.min_y   <= MIN_Y_RESET;
      cfg.max_x   <= MAX_X_RESET;
      cfg.max_y   <= MAX_Y_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLED: cfg.enabled <= cfg_wr_data[0];
        CFG_MIN_X:   cfg.min_x   <= cfg_wr_data;
        CFG_MIN_Y:   cfg.min_y   <= cfg_wr_data;
        CFG_MAX_X:   cfg.max_x   <= cfg_wr_data;
        CFG_MAX_Y:   cfg.max_y   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/ptrk_core.sv
// ----------------------------------------------------------------------------
// ptrk_core: input register, tracker state and per-word update
// Registers one command word, then applies it to the state when the result buffer has room.
// ----------------------------------------------------------------------------
module ptrk_core (
  input  logic               clk,
  input  logic               rst,
  ptrk_in_if.sink            req,
  input  ptrk_pkg::cfg_t     cfg,
  input  logic               buf_space,
  output logic               push_valid,
  output ptrk_pkg::out_word_t push_word
);
  import ptrk_pkg::*;

  // Input register
  logic     s1_valid;
  in_word_t s1;

  // Tracker state
  logic signed [POS_W-1:0] position_x, position_x_next;
  logic signed [POS_W-1:0] position_y, position_y_next;
  logic [SUM_W-1:0]        motion_sum_x, motion_sum_x_next;
  logic [SUM_W-1:0]        motion_sum_y, motion_sum_y_next;
  logic [BUTTON_COUNT-1:0] level_mask, level_mask_next;
  logic [SUM_W-1:0]        press_counts [BUTTON_COUNT];
  logic [SUM_W-1:0]        press_counts_next [BUTTON_COUNT];
  logic [SUM_W-1:0]        press_start [BUTTON_COUNT];
  logic [SUM_W-1:0]        press_start_next [BUTTON_COUNT];
  logic [SUM_W-1:0]        held_totals [BUTTON_COUNT];
  logic [SUM_W-1:0]        held_totals_next [BUTTON_COUNT];

  logic [PRESS_W-1:0]      presses [MAX_BUTTONS];
  logic [BUTTON_COUNT-1:0] levels;
  logic [BUTTON_COUNT-1:0] sel;
  logic                    idx_ok;
  logic                    fire;

  // Add motion, raise to the low limit, then lower to the high limit
  function automatic logic signed [POS_W-1:0] clamp_axis(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W-1:0] mv,
    input logic signed [POS_W-1:0] lo,
    input logic signed [POS_W-1:0] hi
  );
    logic signed [POS_W:0] sum;
    logic signed [POS_W:0] lo_w;
    logic signed [POS_W:0] hi_w;
    sum  = $signed({pos[POS_W-1], pos}) + $signed({mv[POS_W-1], mv});
    lo_w = $signed({lo[POS_W-1], lo});
    hi_w = $signed({hi[POS_W-1], hi});
    if (sum < lo_w) sum = lo_w;
    if (sum > hi_w) sum = hi_w;
    return sum[POS_W-1:0];
  endfunction

  assign fire       = s1_valid && buf_space;
  assign req.ready  = !s1_valid || buf_space;
  assign push_valid = fire;

  // Hold a word until the result buffer has room
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
  end

  assign presses[0] = s1.presses_0;
  assign presses[1] = s1.presses_1;
  assign presses[2] = s1.presses_2;
  assign levels     = s1.button_mask[BUTTON_COUNT-1:0];
  assign idx_ok     = s1.button_index < BTN_IDX_W'(BUTTON_COUNT);

  // Decode one button select line per tracked button
  always_comb begin
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      sel[b] = idx_ok && (s1.button_index == BTN_IDX_W'(b));
    end
  end

  // Next state and result word
  always_comb begin
    position_x_next   = position_x;
    position_y_next   = position_y;
    motion_sum_x_next = motion_sum_x;
    motion_sum_y_next = motion_sum_y;
    level_mask_next   = level_mask;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      press_counts_next[b] = press_counts[b];
      press_start_next[b]  = press_start[b];
      held_totals_next[b]  = held_totals[b];
    end
    push_word.delta_x    = '0;
    push_word.delta_y    = '0;
    push_word.read_value = '0;

    unique case (s1.cmd)
      CMD_SAMPLE: begin
        if (cfg.enabled) begin
          motion_sum_x_next = motion_sum_x + SUM_W'(s1.move_x);
          motion_sum_y_next = motion_sum_y + SUM_W'(s1.move_y);
          position_x_next   = clamp_axis(position_x, s1.move_x, cfg.min_x, cfg.max_x);
          position_y_next   = clamp_axis(position_y, s1.move_y, cfg.min_y, cfg.max_y);
          for (int b = 0; b < BUTTON_COUNT; b++) begin
            press_counts_next[b] = press_counts[b] + {{(SUM_W-PRESS_W){1'b0}}, presses[b]};
            if (levels[b] && !level_mask[b]) begin
              press_start_next[b] = s1.now;
            end else if (!levels[b] && level_mask[b]) begin
              held_totals_next[b] = held_totals[b] + (s1.now - press_start[b]);
            end
          end
          level_mask_next = levels;
        end
      end
      CMD_SET_POS: begin
        position_x_next = s1.new_x;
        position_y_next = s1.new_y;
      end
      CMD_FLUSH: begin
        motion_sum_x_next = '0;
        motion_sum_y_next = '0;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          press_counts_next[b] = '0;
          held_totals_next[b]  = '0;
          press_start_next[b]  = s1.now;
        end
      end
      CMD_BUTTONS: begin
        push_word.read_value = {{(SUM_W-BUTTON_COUNT){1'b0}}, level_mask};
      end
      CMD_READ_DELTA: begin
        push_word.delta_x = motion_sum_x;
        push_word.delta_y = motion_sum_y;
        motion_sum_x_next = '0;
        motion_sum_y_next = '0;
      end
      CMD_DOWN_TIME: begin
        // Held: report time since press and restart; released: drain total
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if (sel[b]) begin
            if (level_mask[b]) begin
              push_word.read_value = s1.now - press_start[b];
              press_start_next[b]  = s1.now;
            end else begin
              push_word.read_value = held_totals[b];
              held_totals_next[b]  = '0;
            end
          end
        end
      end
      CMD_DOWN_COUNT: begin
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if (sel[b]) begin
            push_word.read_value = press_counts[b];
            press_counts_next[b] = '0;
          end
        end
      end
      CMD_BUTTON_STATE: begin
        push_word.read_value = {{(SUM_W-1){1'b0}}, |(sel & level_mask)};
      end
    endcase

    push_word.pos_x = position_x_next;
    push_word.pos_y = position_y_next;
  end

  // Commit the update when the word moves into the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x   <= '0;
      position_y   <= '0;
      motion_sum_x <= '0;
      motion_sum_y <= '0;
      level_mask   <= '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        press_counts[b] <= '0;
        press_start[b]  <= '0;
        held_totals[b]  <= '0;
      end
    end else if (fire) begin
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      motion_sum_x <= motion_sum_x_next;
      motion_sum_y <= motion_sum_y_next;
      level_mask   <= level_mask_next;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        press_counts[b] <= press_counts_next[b];
        press_start[b]  <= press_start_next[b];
        held_totals[b]  <= held_totals_next[b];
      end
    end
  end

endmodule

// File: hdl/ptrk_out_buf.sv
// ----------------------------------------------------------------------------
// ptrk_out_buf: two-entry result buffer
// Decouples the result channel; space depends on registers only.
// ----------------------------------------------------------------------------
module ptrk_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  ptrk_pkg::out_word_t push_word,
  output logic                buf_space,
  ptrk_out_if.source          rsp
);
  import ptrk_pkg::*;

  out_word_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign buf_space = count != OUT_BUF_FULL;
  assign rsp.valid = count != 2'd0;
  assign rsp.data  = slot[rd_ptr];
  assign pop       = rsp.valid && rsp.ready;

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_valid) wr_ptr <= !wr_ptr;
      if (pop)        rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push_valid} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/pointer_tracker_with_button_timing_unit.sv
// ----------------------------------------------------------------------------
// pointer_tracker_with_button_timing_unit: three-button pointer tracker
// Tracks position, motion deltas, press counts and button hold times.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word per handshake (sample, set position, flush
//   or one of the reads); rsp returns exactly one result word for each.
//   The configuration port writes the enable flag and the clamp window and
//   is to be used only while no command is in flight; the block does not enforce it.
// Flow: a word waits in the input register until the result buffer has room
//   and is then applied to the state as its result enters the buffer.
// Throughput: one word per cycle while the buffer has room; the single
//   registered pass is set by the 32-bit hold-time add/subtract path.
// Reset: clears position, sums, counts, hold times and button levels,
//   disables sampling and restores the window to 0..319 by 0..199.
//   Nothing else is swept; the block is ready in the cycle after reset.
// Stall: a two-entry result buffer plus the input register absorb up to
//   three words while rsp is held off; then req.ready drops. req.ready
//   comes from registers only, never from rsp.ready directly.
// ----------------------------------------------------------------------------
module pointer_tracker_with_button_timing_unit (
  input  logic                             clk,
  input  logic                             rst,
  ptrk_in_if.sink                          req,
  ptrk_out_if.source                       rsp,
  input  logic                             cfg_wr_en,
  input  logic [ptrk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptrk_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import ptrk_pkg::*;

  cfg_t      cfg;
  logic      push_valid;
  out_word_t push_word;
  logic      buf_space;

  // Configuration registers
  ptrk_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  // Input register and state update
  ptrk_core u_core (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .buf_space  (buf_space),
    .push_valid (push_valid),
    .push_word  (push_word)
  );

  // Result buffer
  ptrk_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_word  (push_word),
    .buf_space  (buf_space),
    .rsp        (rsp)
  );

`ifndef NO_ASSERTIONS
  // A pushed word must show up on the result channel
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> rsp.valid)
    else $error("pushed result not visible on rsp");

  // A full buffer always presents a word
  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    !buf_space |-> rsp.valid)
    else $error("result buffer full but rsp.valid low");

  // An accepted word is either applied next cycle or waiting on a full buffer
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (push_valid || !buf_space))
    else $error("accepted word neither applied nor blocked by full buffer");
`endif

endmodule
